// ----- hdl/lfat_pkg.sv -----
// ----------------------------------------------------------------------------
// lfat_pkg
// Shared types and constants of the flow aging table: channel words,
// the queued command word, opcodes, causes and defaults.
// ----------------------------------------------------------------------------
package lfat_pkg;

  localparam int ENTRIES_DEF     = 64;
  localparam int KEY_BITS_DEF    = 32;
  localparam int TIME_BITS_DEF   = 32;

  localparam int KEY_FIELD_BITS  = 32;
  localparam int TIME_FIELD_BITS = 32;
  localparam int CFG_BITS        = 32;

  localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = 32'd60;

  localparam logic OP_TOUCH = 1'b0;
  localparam logic OP_SWEEP = 1'b1;

  localparam logic CAUSE_EXPIRED = 1'b0;
  localparam logic CAUSE_EVICTED = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic                       opcode;
    logic [KEY_FIELD_BITS-1:0]  flow_key;
    logic [TIME_FIELD_BITS-1:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [KEY_FIELD_BITS-1:0] removed_key;
    logic                      cause;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic                       is_sweep;
    logic [KEY_FIELD_BITS-1:0]  key;
    logic [TIME_FIELD_BITS-1:0] now;
  } cmd_t;

endpackage

// ----- hdl/lru_flow_aging_table.sv -----
// ----------------------------------------------------------------------------
// lru_flow_aging_table
// Recency-ordered flow table with time stamps, touch and timeout sweep.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   valid/ready channel of commands: touch (move or insert a flow key
//          at the newest position, stamped with now_seconds) or sweep
//          (remove expired entries from the oldest end).
//   out_*  valid/ready channel of removed keys; last marks the final word
//          caused by one command. A touch that hits a full table with a new
//          key evicts the oldest entry (cause 1); a sweep reports each
//          expired entry (cause 0) until the first one still alive.
//   cfg_*  write channel for timeout_seconds, always ready; write it only
//          while the block is idle.
// Timing: a two-deep command queue decouples input from the table engine.
//   A touch runs in the engine as a parallel key compare over all slots,
//   then a shift-and-append; a sweep fetches, then removes expired entries
//   one at a time. The engine takes no new command until it is back in
//   idle. Results leave through one output register.
// Reset empties the table and loads a timeout of 60. A stalled receiver
// holds the engine at its next result; the queue keeps taking commands
// until it is full.
module lru_flow_aging_table #(
  parameter int ENTRIES   = lfat_pkg::ENTRIES_DEF,
  parameter int KEY_BITS  = lfat_pkg::KEY_BITS_DEF,
  parameter int TIME_BITS = lfat_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lfat_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lfat_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfat_pkg::CFG_BITS-1:0] cfg_data
);
  import lfat_pkg::*;

  logic [CFG_BITS-1:0] timeout_r, timeout_nxt;
  logic                cmd_valid, cmd_ready;
  cmd_t                cmd;

  assign cfg_ready   = 1'b1;
  assign timeout_nxt = (cfg_valid && cfg_ready) ? cfg_data : timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  lfat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  lfat_back #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .timeout   (timeout_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- hdl/lfat_front.sv -----
// ----------------------------------------------------------------------------
// lfat_front
// Input side: accepts words, decodes the opcode into a command and holds
// commands in a short queue until the table engine takes them.
// ----------------------------------------------------------------------------
module lfat_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lfat_pkg::in_item_t in_item,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output lfat_pkg::cmd_t   cmd
);
  import lfat_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                q_mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] fill_r, fill_nxt;
  logic                push, pop;
  cmd_t                new_cmd;

  assign in_ready  = (fill_r != CNT_BITS'(QUEUE_DEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    new_cmd.is_sweep = (in_item.opcode == OP_SWEEP);
    new_cmd.key      = in_item.flow_key;
    new_cmd.now      = in_item.now_seconds;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= CNT_BITS'(QUEUE_DEPTH)) && (cmd_valid || !pop))
    else $error("queue fill out of range or pop from empty queue");

endmodule

// ----- hdl/lfat_back.sv -----
// ----------------------------------------------------------------------------
// lfat_back
// Table engine: the slot cells, the per-slot key match, the shift that
// closes a gap, the sweep sequencer and the result register.
// ----------------------------------------------------------------------------
module lfat_back #(
  parameter int ENTRIES   = lfat_pkg::ENTRIES_DEF,
  parameter int KEY_BITS  = lfat_pkg::KEY_BITS_DEF,
  parameter int TIME_BITS = lfat_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  lfat_pkg::cmd_t                cmd,
  input  logic [lfat_pkg::CFG_BITS-1:0] timeout,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lfat_pkg::out_item_t           out_item
);
  import lfat_pkg::*;

  localparam int CNT_BITS = $clog2(ENTRIES + 1);
  localparam int IDX_BITS = $clog2(ENTRIES);
  localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic [KEY_BITS-1:0]  key_r   [ENTRIES];
  logic [TIME_BITS-1:0] stamp_r [ENTRIES];

  logic [KEY_BITS-1:0]  cmd_key_r;
  logic [TIME_BITS-1:0] cmd_now_r;
  logic                 found_r;
  logic [ENTRIES-1:0]   drop_r;

  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic [KEY_BITS-1:0]  head_key;
  logic [ENTRIES-1:0]   match;
  logic [ENTRIES-1:0]   ge;
  logic                 pop;

  logic                 full, evict, out_free, emit;
  logic                 shift_en, app_en;
  logic [ENTRIES-1:0]   drop_vec;
  logic [CNT_BITS-1:0]  app_cnt;
  logic [IDX_BITS-1:0]  app_idx;
  logic [TIME_BITS-1:0] age0, age1;
  logic                 exp0, exp1;

  assign cmd_ready = (state_r == ST_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign head_key  = KEY_BITS'(cmd.key);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // per-slot compare and "at or above the hit" mask
  for (genvar g = 0; g < ENTRIES; g++) begin : g_match
    localparam logic [ENTRIES-1:0] LO_MASK = {ENTRIES{1'b1}} >> (ENTRIES - 1 - g);
    assign match[g] = (CNT_BITS'(g) < count_r) && (key_r[g] == head_key);
    assign ge[g]    = |(match & LO_MASK);
  end

  assign full     = (count_r == CNT_BITS'(ENTRIES));
  assign evict    = !found_r && full;
  assign out_free = !out_valid_r || out_ready;
  assign age0     = cmd_now_r - stamp_r[0];
  assign age1     = cmd_now_r - stamp_r[1];
  assign exp0     = (count_r != '0) && (CMP_BITS'(age0) > CMP_BITS'(timeout));
  assign exp1     = (count_r > CNT_BITS'(1)) && (CMP_BITS'(age1) > CMP_BITS'(timeout));
  assign app_cnt  = count_r - CNT_BITS'(found_r || evict);
  assign app_idx  = app_cnt[IDX_BITS-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    shift_en      = 1'b0;
    app_en        = 1'b0;
    drop_vec      = '0;
    emit          = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = cmd.is_sweep ? ST_SWEEP : ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!evict || out_free) begin
          shift_en  = 1'b1;
          app_en    = 1'b1;
          drop_vec  = found_r ? drop_r : (evict ? {ENTRIES{1'b1}} : '0);
          count_nxt = app_cnt + 1'b1;
          state_nxt = ST_IDLE;
          if (evict) begin
            emit                     = 1'b1;
            out_item_nxt.removed_key = KEY_FIELD_BITS'(key_r[0]);
            out_item_nxt.cause       = CAUSE_EVICTED;
            out_item_nxt.last        = 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        if (!exp0) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          emit                     = 1'b1;
          out_item_nxt.removed_key = KEY_FIELD_BITS'(key_r[0]);
          out_item_nxt.cause       = CAUSE_EXPIRED;
          out_item_nxt.last        = !exp1;
          shift_en                 = 1'b1;
          drop_vec                 = {ENTRIES{1'b1}};
          count_nxt                = count_r - 1'b1;
          if (!exp1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (pop) begin
      cmd_key_r <= head_key;
      cmd_now_r <= TIME_BITS'(cmd.now);
      found_r   <= |match;
      drop_r    <= ge;
    end
  end

  // slot cells: take the new entry, or the neighbor above when closing a gap
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [KEY_BITS-1:0]  up_key;
    logic [TIME_BITS-1:0] up_stamp;
    if (g < ENTRIES - 1) begin : g_up
      assign up_key   = key_r[g+1];
      assign up_stamp = stamp_r[g+1];
    end else begin : g_top
      assign up_key   = key_r[g];
      assign up_stamp = stamp_r[g];
    end
    always_ff @(posedge clk) begin
      if (app_en && (app_idx == IDX_BITS'(g))) begin
        key_r[g]   <= cmd_key_r;
        stamp_r[g] <= cmd_now_r;
      end else if (shift_en && drop_vec[g]) begin
        key_r[g]   <= up_key;
        stamp_r[g] <= up_stamp;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(ENTRIES))
    else $error("entry count above table size");

  a_evict_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.cause == CAUSE_EVICTED)) |-> out_item_r.last)
    else $error("eviction word not marked last");

  a_apply_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPLY) |-> ($past(state_r) == ST_IDLE || $past(state_r) == ST_APPLY))
    else $error("apply step entered without a fetched command");

endmodule

// ----- dv/tb_lru_flow_aging_table.sv -----
// ----------------------------------------------------------------------------
// tb_lru_flow_aging_table
// Self-checking bench for the flow aging table: a short table of probes with
// hand-worked removals, a table fill that forces evictions behind a long
// receiver stall, then random touch/sweep traffic under several timeouts,
// all scored in order against the hand-worked rows or a recency-list model.
// ----------------------------------------------------------------------------
module tb_lru_flow_aging_table;
  import lfat_pkg::*;

  localparam int TABLE_SLOTS  = ENTRIES_DEF;
  localparam int SETTLE_WAIT  = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int SEG_COUNT    = 6;
  localparam int SEG_WORDS    = 38;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [31:0] now;
    logic        typed;
    logic        hit;
    logic [31:0] hit_key;
  } probe_t;

  // hand-worked rows carry their removal; the rest go through the model
  localparam probe_t PROBES [18] = '{
    '{OP_SWEEP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0},  // empty table
    '{OP_TOUCH, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{OP_TOUCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{OP_SWEEP, 32'hFFFF_FFFF, 32'h0000_003C, 1'b1, 1'b0, 32'h0},  // age == timeout
    '{OP_SWEEP, 32'h1234_5678, 32'h0000_003D, 1'b0, 1'b0, 32'h0},  // both, one wrapped
    '{OP_TOUCH, 32'hA5A5_A5A5, 32'h0000_0064, 1'b1, 1'b0, 32'h0},
    '{OP_SWEEP, 32'h5A5A_5A5A, 32'h0000_00A1, 1'b1, 1'b1, 32'hA5A5_A5A5},  // lone entry
    '{OP_TOUCH, 32'h0000_0001, 32'h0000_00C8, 1'b1, 1'b0, 32'h0},
    '{OP_TOUCH, 32'h0000_0002, 32'h0000_00C9, 1'b1, 1'b0, 32'h0},
    '{OP_TOUCH, 32'h0000_0001, 32'h0000_00E6, 1'b1, 1'b0, 32'h0},  // re-touch moves it
    '{OP_SWEEP, 32'h0000_0000, 32'h0000_0106, 1'b1, 1'b1, 32'h0000_0002},
    '{OP_SWEEP, 32'h0000_0000, 32'h0000_0122, 1'b1, 1'b0, 32'h0},
    '{OP_SWEEP, 32'h0000_0000, 32'h0000_0123, 1'b1, 1'b1, 32'h0000_0001},
    '{OP_TOUCH, 32'h8000_0000, 32'hFFFF_FFF0, 1'b1, 1'b0, 32'h0},
    '{OP_TOUCH, 32'h7FFF_FFFF, 32'h0000_000F, 1'b1, 1'b0, 32'h0},
    '{OP_SWEEP, 32'h0000_0000, 32'h0000_002C, 1'b1, 1'b0, 32'h0},
    '{OP_SWEEP, 32'h0000_0000, 32'h0000_002D, 1'b1, 1'b1, 32'h8000_0000},
    '{OP_SWEEP, 32'h0000_0000, 32'h0000_004C, 1'b1, 1'b1, 32'h7FFF_FFFF}
  };

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  // model of the table: index 0 is the oldest entry
  logic [31:0]         recency_keys[$];
  logic [31:0]         recency_stamps[$];
  logic [CFG_BITS-1:0] timeout_now = TIMEOUT_RESET;
  out_item_t           removals_now[$];
  out_item_t           removals_due[$];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_asks     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int fail_count    = 0;

  lru_flow_aging_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void predict_removals(input in_item_t w);
    logic [31:0] age;
    bit          found;
    int          i;
    removals_now.delete();
    if (w.opcode == OP_TOUCH) begin
      found = 1'b0;
      for (i = 0; i < recency_keys.size(); i++) begin
        if (recency_keys[i] == w.flow_key) begin
          recency_keys.delete(i);
          recency_stamps.delete(i);
          found = 1'b1;
          break;
        end
      end
      if (!found && recency_keys.size() >= TABLE_SLOTS) begin
        removals_now.push_back('{removed_key: recency_keys[0], cause: CAUSE_EVICTED,
                                 last: 1'b0});
        void'(recency_keys.pop_front());
        void'(recency_stamps.pop_front());
      end
      recency_keys.push_back(w.flow_key);
      recency_stamps.push_back(w.now_seconds);
    end else begin
      while (recency_keys.size() > 0) begin
        age = w.now_seconds - recency_stamps[0];
        if (age <= timeout_now) break;
        removals_now.push_back('{removed_key: recency_keys[0], cause: CAUSE_EXPIRED,
                                 last: 1'b0});
        void'(recency_keys.pop_front());
        void'(recency_stamps.pop_front());
      end
    end
    if (removals_now.size() > 0) removals_now[removals_now.size()-1].last = 1'b1;
  endfunction

  task automatic offer_word(input in_item_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_word(input in_item_t w);
    offer_word(w);
    predict_removals(w);
    foreach (removals_now[i]) removals_due.push_back(removals_now[i]);
  endtask

  // touches leave nothing to wait on, so give the engine time to settle
  task automatic drain_table();
    in_valid <= 1'b0;
    while (removals_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [CFG_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timeout_now = v;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (removals_due.size() == 0) begin
        $error("unexpected word: removed_key %h cause %0d last %0d",
               out_item.removed_key, out_item.cause, out_item.last);
        fail_count++;
      end else begin
        want = removals_due.pop_front();
        if (out_item.removed_key !== want.removed_key) begin
          $error("removed_key: expected %h, got %h", want.removed_key,
                 out_item.removed_key);
          fail_count++;
        end
        if (out_item.cause !== want.cause) begin
          $error("cause: expected %0d, got %0d", want.cause, out_item.cause);
          fail_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    in_item_t            w;
    logic [31:0]         clock_s;
    logic [31:0]         key_tag;
    logic [CFG_BITS-1:0] tmo;
    int                  step_max;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct   = 21;
    out_stall_pct = 83;

    foreach (PROBES[p]) begin
      w.opcode      = PROBES[p].op;
      w.flow_key    = PROBES[p].key;
      w.now_seconds = PROBES[p].now;
      offer_word(w);
      predict_removals(w);
      if (PROBES[p].typed) begin
        if (PROBES[p].hit)
          removals_due.push_back('{removed_key: PROBES[p].hit_key, cause: CAUSE_EXPIRED,
                                   last: 1'b1});
      end else begin
        foreach (removals_now[i]) removals_due.push_back(removals_now[i]);
      end
    end

    // fill the table behind a stalled receiver so evictions back up the input
    hold_asks <= hold_asks + 1;
    key_tag = $urandom() & 32'hFFFF_0000;
    clock_s = $urandom();
    w.opcode = OP_TOUCH;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      w.flow_key    = key_tag + i;
      w.now_seconds = clock_s + i;
      run_word(w);
    end
    w.flow_key = key_tag + 5;  // already present while full: no word
    run_word(w);
    for (int i = 0; i < 16; i++) begin
      w.flow_key    = key_tag + 1000 + i;
      w.now_seconds = clock_s + TABLE_SLOTS + i;
      run_word(w);
    end
    // one sweep clears the full table
    w.opcode      = OP_SWEEP;
    w.flow_key    = $urandom();
    w.now_seconds = clock_s + 1000;
    run_word(w);
    drain_table();

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg)
        0:       tmo = '0;
        1:       tmo = '1;
        2:       tmo = $urandom_range(1, 100);
        3:       tmo = TIMEOUT_RESET;
        4:       tmo = $urandom();
        default: tmo = $urandom_range(20, 150);
      endcase
      if (seg < 2) begin
        in_idle_pct   = 21;
        out_stall_pct = 83;
      end else if (seg < 4) begin
        in_idle_pct   = 83;
        out_stall_pct = 21;
      end else begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end
      write_timeout(tmo);
      step_max = (tmo < 200) ? tmo / 3 + 2 : 40;
      key_tag  = $urandom() & 32'hFFFF_FF00;
      clock_s  = $urandom();
      for (int n = 0; n < SEG_WORDS; n++) begin
        if (seg == 2 && n == SEG_WORDS / 2) drain_table();
        w.opcode = ($urandom_range(99) < 25) ? OP_SWEEP : OP_TOUCH;
        // rare jumps in time, occasionally across the wrap
        if ($urandom_range(19) == 0) clock_s = $urandom();
        else clock_s = clock_s + $urandom_range(0, step_max);
        w.now_seconds = clock_s;
        w.flow_key = ($urandom_range(9) < 7) ? (key_tag | $urandom_range(0, 79))
                                             : $urandom();
        run_word(w);
      end
      drain_table();
    end

    if (fail_count == 0) begin
      $display("tb_lru_flow_aging_table OK");
    end else begin
      $display("tb_lru_flow_aging_table NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_lru_flow_aging_table NOT OK");
    $finish;
  end

endmodule
